// ===== hw/rtl/keyed_beacon_digest_assert.svh =====
// Assertion macros for the keyed beacon digest block.
// Used by modules that check their own logic; relies on clk and rst_n in scope.
`ifndef KEYED_BEACON_DIGEST_ASSERT_SVH
`define KEYED_BEACON_DIGEST_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define KBD_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define KBD_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KBD_CHECK(lbl, expr, msg)

`define KBD_CHECK_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/kbd_pkg.sv =====
// Shared constants, types and hash helpers for the keyed beacon digest.
// No dependencies.
package kbd_pkg;

    localparam int LANES        = 8;
    localparam int BEACON_BYTES = 18;
    localparam int KEY_BYTES    = 16;
    localparam int MSG_BYTES    = BEACON_BYTES + KEY_BYTES;
    localparam int BEACON_BITS  = 8 * BEACON_BYTES;
    localparam int KEY_BITS     = 8 * KEY_BYTES;
    localparam int TAG_WORDS    = 4;
    localparam int MIX_SHIFT    = 15;
    localparam int SEED_STEP    = 7919;
    localparam int CFG_IDX_W    = 8;

    localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
    localparam logic [63:0] KEY_RESET = 64'hABAB_ABAB_ABAB_ABAB;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = CFG_IDX_W'(1);

    typedef logic [LANES-1:0][31:0] lane_vec_t;

    typedef struct packed {
        logic [BEACON_BITS-1:0]         beacon;
        logic [TAG_WORDS-1:0][63:0]     tag;
    } carry_t;

    typedef struct packed {
        logic [TAG_WORDS-1:0][63:0]     digest;
        logic                           match;
    } result_t;

    function automatic logic [31:0] lane_seed(input int k);
        return 32'(1 + k * SEED_STEP);
    endfunction

    function automatic logic [31:0] fold(input logic [31:0] h);
        return h ^ (h >> MIX_SHIFT);
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * MIX_MUL;
    endfunction

endpackage

// ===== hw/rtl/kbd_ifs.sv =====
// Channel interfaces: beacon input, digest result and key write port.
// Depends on kbd_pkg.
interface kbd_beacon_if;
    logic        valid;
    logic        ready;
    logic [7:0]  action;
    logic [31:0] next_hop;
    logic [7:0]  role;
    logic [63:0] stamp_ns;
    logic [31:0] node_ident;
    logic [63:0] tag_in_0;
    logic [63:0] tag_in_1;
    logic [63:0] tag_in_2;
    logic [63:0] tag_in_3;

    modport source (output valid, action, next_hop, role, stamp_ns, node_ident,
                    tag_in_0, tag_in_1, tag_in_2, tag_in_3, input ready);
    modport sink   (input valid, action, next_hop, role, stamp_ns, node_ident,
                    tag_in_0, tag_in_1, tag_in_2, tag_in_3, output ready);
endinterface

interface kbd_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_0;
    logic [63:0] digest_1;
    logic [63:0] digest_2;
    logic [63:0] digest_3;
    logic        tag_match;

    modport source (output valid, digest_0, digest_1, digest_2, digest_3, tag_match,
                    input ready);
    modport sink   (input valid, digest_0, digest_1, digest_2, digest_3, tag_match,
                    output ready);
endinterface

interface kbd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [kbd_pkg::CFG_IDX_W-1:0] index;
    logic [63:0]                   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/kbd_stage.sv =====
// One pipeline stage: folds the previous product (or, with seed_sel, takes the lane seed),
// mixes in one message byte and multiplies, for all eight lanes. Depends on kbd_pkg.
module kbd_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               seed_sel,
    input  logic               in_valid,
    input  kbd_pkg::lane_vec_t in_prod,
    input  kbd_pkg::carry_t    in_carry,
    input  logic [7:0]         msg_byte,
    output logic               out_valid,
    output kbd_pkg::lane_vec_t out_prod,
    output kbd_pkg::carry_t    out_carry
);

    logic               valid_reg;
    kbd_pkg::lane_vec_t prod_reg;
    kbd_pkg::lane_vec_t prod_next;
    kbd_pkg::carry_t    carry_reg;

    always_comb
    begin
        for (int k = 0; k < kbd_pkg::LANES; k++)
        begin
            if (seed_sel)
            begin
                prod_next[k] = kbd_pkg::mix(kbd_pkg::lane_seed(k), msg_byte);
            end
            else
            begin
                prod_next[k] = kbd_pkg::mix(kbd_pkg::fold(in_prod[k]), msg_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            carry_reg <= in_carry;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_carry = carry_reg;

endmodule

// ===== hw/rtl/kbd_out_buf.sv =====
// Two-entry result buffer that decouples the pipeline from the result sink.
// Depends on kbd_pkg and keyed_beacon_digest_assert.svh.
`include "keyed_beacon_digest_assert.svh"

module kbd_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kbd_pkg::result_t push_data,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output kbd_pkg::result_t out_data
);

    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    kbd_pkg::result_t head_reg;
    kbd_pkg::result_t head_next;
    kbd_pkg::result_t tail_reg;
    kbd_pkg::result_t tail_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign out_data  = head_reg;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        case ({push, pop})
            2'b10:
            begin
                count_next = count_reg + 2'd1;
                if (count_reg == 2'd0)
                begin
                    head_next = push_data;
                end
                else
                begin
                    tail_next = push_data;
                end
            end
            2'b01:
            begin
                count_next = count_reg - 2'd1;
                head_next  = tail_reg;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_next = push_data;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    `KBD_CHECK(a_count_range, count_reg != 2'd3, "result buffer count out of range")
    `KBD_CHECK(a_no_overflow, !(push && count_reg == 2'd2), "push into full result buffer")
    `KBD_CHECK_NEXT(a_load_empty, push && count_reg == 2'd0, head_reg == $past(push_data), "empty buffer did not load head")
    `KBD_CHECK_NEXT(a_fill_step, push && !pop && count_reg == 2'd1, count_reg == 2'd2, "buffer count did not advance")

endmodule

// ===== hw/rtl/keyed_beacon_digest.sv =====
// Keyed beacon digest: eight multiply-xor-shift lanes over a 34-byte message.
// An accepted beacon passes the stage registers and then the result buffer before its result beat.
// Throughput: one beacon per cycle; 34 multiply stages, one per message byte.
// The pipeline holds only when the two-entry result buffer is full.
// Reset: asynchronous active low; clears valid bits and the buffer, keys reload 0xAB bytes.
// Depends on kbd_pkg, kbd_ifs, kbd_stage and kbd_out_buf.
module keyed_beacon_digest (
    input  logic clk,
    input  logic rst_n,
    kbd_beacon_if.sink   beacon,
    kbd_result_if.source result,
    kbd_cfg_if.sink      cfg
);

    localparam int N = kbd_pkg::MSG_BYTES;

    logic [63:0]                  key_upper_reg;
    logic [63:0]                  key_lower_reg;
    logic [kbd_pkg::KEY_BITS-1:0] key_all;
    logic                         en;
    logic                         push;

    logic               valid_w [0:N];
    kbd_pkg::lane_vec_t prod_w  [0:N];
    kbd_pkg::carry_t    carry_w [0:N];
    logic [7:0]         byte_w  [0:N-1];

    kbd_pkg::lane_vec_t hash_w;
    kbd_pkg::result_t   res_w;
    kbd_pkg::result_t   head_w;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= kbd_pkg::KEY_RESET;
            key_lower_reg <= kbd_pkg::KEY_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                kbd_pkg::REG_KEY_UPPER: key_upper_reg <= cfg.data;
                kbd_pkg::REG_KEY_LOWER: key_lower_reg <= cfg.data;
                default:                key_upper_reg <= key_upper_reg;
            endcase
        end
    end

    assign key_all = {key_upper_reg, key_lower_reg};

    assign beacon.ready = en;
    assign valid_w[0]   = beacon.valid;
    assign prod_w[0]    = '0;
    assign carry_w[0].beacon = {beacon.action, beacon.next_hop, beacon.role,
                                beacon.stamp_ns, beacon.node_ident};
    assign carry_w[0].tag    = {beacon.tag_in_0, beacon.tag_in_1,
                                beacon.tag_in_2, beacon.tag_in_3};

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        if (s < kbd_pkg::BEACON_BYTES)
        begin : g_beacon_byte
            assign byte_w[s] = carry_w[s].beacon[kbd_pkg::BEACON_BITS-1-8*s -: 8];
        end
        else
        begin : g_key_byte
            assign byte_w[s] =
                key_all[kbd_pkg::KEY_BITS-1-8*(s-kbd_pkg::BEACON_BYTES) -: 8];
        end

        kbd_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .seed_sel  (s == 0),
            .in_valid  (valid_w[s]),
            .in_prod   (prod_w[s]),
            .in_carry  (carry_w[s]),
            .msg_byte  (byte_w[s]),
            .out_valid (valid_w[s+1]),
            .out_prod  (prod_w[s+1]),
            .out_carry (carry_w[s+1])
        );
    end

    always_comb
    begin
        for (int k = 0; k < kbd_pkg::LANES; k++)
        begin
            hash_w[k] = kbd_pkg::fold(prod_w[N][k]);
        end
        for (int w = 0; w < kbd_pkg::TAG_WORDS; w++)
        begin
            res_w.digest[kbd_pkg::TAG_WORDS-1-w] = {hash_w[2*w], hash_w[2*w+1]};
        end
        res_w.match = (res_w.digest == carry_w[N].tag);
    end

    assign push = en && valid_w[N];

    kbd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res_w),
        .space     (en),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (head_w)
    );

    assign result.digest_0  = head_w.digest[3];
    assign result.digest_1  = head_w.digest[2];
    assign result.digest_2  = head_w.digest[1];
    assign result.digest_3  = head_w.digest[0];
    assign result.tag_match = head_w.match;

endmodule
